// ===== sv/tae_pkg.sv =====
// ----------------------------------------------------------------------------
// tae_pkg
// Types, encoding masks and decode helpers shared by the Thumb ADD execute unit.
// ----------------------------------------------------------------------------
package tae_pkg;

  typedef enum logic [1:0] {
    ACT_EXEC       = 2'd0,
    ACT_LOAD_REG   = 2'd1,
    ACT_LOAD_FLAGS = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_IMPL = 2'd1,
    ST_UNPRED   = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    CL_ADC,
    CL_ADD_IMM3,
    CL_ADD_IMM8,
    CL_ADD_REG,
    CL_ADD_RD_SP,
    CL_ADD_SP_SP,
    CL_ADD_HI,
    CL_ADD_T3,
    CL_NONE
  } iclass_t;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_PC = 4'd15;

  localparam logic [15:0] MASK_ADC    = 16'hffc0;
  localparam logic [15:0] PAT_ADC     = 16'h4140;
  localparam logic [15:0] MASK_IMM3   = 16'hfe00;
  localparam logic [15:0] PAT_IMM3    = 16'h1c00;
  localparam logic [15:0] MASK_IMM8   = 16'hf800;
  localparam logic [15:0] PAT_IMM8    = 16'h3000;
  localparam logic [15:0] MASK_REG    = 16'hfe00;
  localparam logic [15:0] PAT_REG     = 16'h1800;
  localparam logic [15:0] MASK_RD_SP  = 16'hf800;
  localparam logic [15:0] PAT_RD_SP   = 16'ha800;
  localparam logic [15:0] MASK_SP_SP  = 16'hff80;
  localparam logic [15:0] PAT_SP_SP   = 16'hb000;
  localparam logic [15:0] MASK_HI     = 16'hff00;
  localparam logic [15:0] PAT_HI      = 16'h4400;
  localparam logic [31:0] MASK_T3     = 32'hfbe08000;
  localparam logic [31:0] PAT_T3      = 32'hf1000000;

  // one item held between the input register and the result register
  typedef struct packed {
    action_t     action;
    logic [31:0] instruction;
    logic        in_it_block;
    logic        last_in_it_block;
    logic [3:0]  load_index;
    logic [31:0] load_value;
    iclass_t     iclass;
  } item_t;

  // register file / flag write request
  typedef struct packed {
    logic        reg_we;
    logic [3:0]  reg_idx;
    logic [31:0] reg_val;
    logic        flag_we;
    logic [3:0]  flags;
  } wb_t;

  typedef struct packed {
    logic [3:0] addr_a;
    logic [3:0] addr_b;
  } raddr_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } imm_t;

  function automatic iclass_t classify(input logic [31:0] ins, input logic wide);
    logic narrow;
    iclass_t c;
    narrow = !wide && (ins[31:16] == 16'h0000);
    priority if (narrow && ((ins[15:0] & MASK_ADC) == PAT_ADC))        c = CL_ADC;
    else if (narrow && ((ins[15:0] & MASK_IMM3) == PAT_IMM3))         c = CL_ADD_IMM3;
    else if (narrow && ((ins[15:0] & MASK_IMM8) == PAT_IMM8))         c = CL_ADD_IMM8;
    else if (narrow && ((ins[15:0] & MASK_REG) == PAT_REG))           c = CL_ADD_REG;
    else if (narrow && ((ins[15:0] & MASK_RD_SP) == PAT_RD_SP))       c = CL_ADD_RD_SP;
    else if (narrow && ((ins[15:0] & MASK_SP_SP) == PAT_SP_SP))       c = CL_ADD_SP_SP;
    else if (narrow && ((ins[15:0] & MASK_HI) == PAT_HI))             c = CL_ADD_HI;
    else if (wide && ((ins & MASK_T3) == PAT_T3))                     c = CL_ADD_T3;
    else                                                              c = CL_NONE;
    return c;
  endfunction

  // source registers each encoding reads; unused ports point anywhere
  function automatic raddr_t operand_addr(input iclass_t c, input logic [31:0] ins);
    raddr_t r;
    r.addr_a = {1'b0, ins[2:0]};
    r.addr_b = {1'b0, ins[5:3]};
    unique case (c)
      CL_ADC:       begin r.addr_a = {1'b0, ins[2:0]};  r.addr_b = {1'b0, ins[5:3]}; end
      CL_ADD_IMM3:  r.addr_a = {1'b0, ins[5:3]};
      CL_ADD_IMM8:  r.addr_a = {1'b0, ins[10:8]};
      CL_ADD_REG:   begin r.addr_a = {1'b0, ins[5:3]};  r.addr_b = {1'b0, ins[8:6]}; end
      CL_ADD_RD_SP: r.addr_a = REG_SP;
      CL_ADD_SP_SP: r.addr_a = REG_SP;
      CL_ADD_HI:    begin r.addr_a = {ins[7], ins[2:0]}; r.addr_b = ins[6:3]; end
      CL_ADD_T3:    r.addr_a = ins[19:16];
      default:      ;
    endcase
    return r;
  endfunction

  function automatic imm_t expand_imm(input logic [11:0] imm12);
    imm_t r;
    logic [7:0]  b;
    logic [63:0] dbl;
    b = imm12[7:0];
    r.ok = 1'b1;
    if (imm12[11:10] == 2'b00) begin
      unique case (imm12[9:8])
        2'd0: r.value = {24'h0, b};
        2'd1: r.value = {8'h0, b, 8'h0, b};
        2'd2: r.value = {b, 8'h0, b, 8'h0};
        default: r.value = {b, b, b, b};
      endcase
      // replicated pattern with a zero byte is unpredictable
      if (imm12[9:8] != 2'd0 && b == 8'h00) r.ok = 1'b0;
    end else begin
      dbl = {24'h0, 1'b1, imm12[6:0], 24'h0, 1'b1, imm12[6:0]};
      dbl = dbl >> imm12[11:7];
      r.value = dbl[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/tae_regfile.sv =====
// ----------------------------------------------------------------------------
// tae_regfile
// 16 x 32 register file and NZCV flags; two registered read ports with
// write bypass so an item reads what the item ahead of it writes.
// ----------------------------------------------------------------------------
module tae_regfile (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  tae_pkg::raddr_t   raddr,
  input  logic              wr_en,
  input  tae_pkg::wb_t      wb,
  output logic [31:0]       op_a,
  output logic [31:0]       op_b,
  output logic [3:0]        flags
);

  logic [31:0] regs_r [16];
  logic [3:0]  nzcv_r;
  logic [31:0] op_a_r, op_a_nxt;
  logic [31:0] op_b_r, op_b_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic        reg_we, flag_we;

  assign reg_we  = wr_en && wb.reg_we;
  assign flag_we = wr_en && wb.flag_we;

  always_comb begin
    op_a_nxt  = (reg_we && wb.reg_idx == raddr.addr_a) ? wb.reg_val : regs_r[raddr.addr_a];
    op_b_nxt  = (reg_we && wb.reg_idx == raddr.addr_b) ? wb.reg_val : regs_r[raddr.addr_b];
    flags_nxt = flag_we ? wb.flags : nzcv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) regs_r[i] <= '0;
      nzcv_r <= '0;
    end else begin
      if (reg_we)  regs_r[wb.reg_idx] <= wb.reg_val;
      if (flag_we) nzcv_r <= wb.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      op_a_r  <= op_a_nxt;
      op_b_r  <= op_b_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign op_a  = op_a_r;
  assign op_b  = op_b_r;
  assign flags = flags_r;

endmodule

// ===== sv/tae_execute.sv =====
// ----------------------------------------------------------------------------
// tae_execute
// Combinational execute: one adder with AddWithCarry flags, encoding checks,
// register/flag write request and result fields.
// ----------------------------------------------------------------------------
module tae_execute (
  input  tae_pkg::item_t    item,
  input  logic [31:0]       op_a,
  input  logic [31:0]       op_b,
  input  logic [3:0]        flags_in,
  output tae_pkg::wb_t      wb,
  output tae_pkg::status_t  status,
  output logic [3:0]        flags_out
);

  logic [31:0] ins;
  logic [31:0] add_b;
  logic        cin;
  logic [32:0] sum;
  logic [31:0] res;
  logic        ovf;
  logic [3:0]  nf;
  logic [3:0]  rd_hi, rd_t3, rn_t3;
  logic        s_bit;
  tae_pkg::imm_t imm;
  logic        wr, fw;
  logic [3:0]  d;
  logic [31:0] val;
  tae_pkg::status_t st;

  assign ins   = item.instruction;
  assign rd_hi = {ins[7], ins[2:0]};
  assign rd_t3 = ins[11:8];
  assign rn_t3 = ins[19:16];
  assign s_bit = ins[20];
  assign imm   = tae_pkg::expand_imm({ins[26], ins[14:12], ins[7:0]});

  always_comb begin
    add_b = op_b;
    cin   = 1'b0;
    unique case (item.iclass)
      tae_pkg::CL_ADC:       cin = flags_in[1];
      tae_pkg::CL_ADD_IMM3:  add_b = {29'h0, ins[8:6]};
      tae_pkg::CL_ADD_IMM8:  add_b = {24'h0, ins[7:0]};
      tae_pkg::CL_ADD_RD_SP: add_b = {22'h0, ins[7:0], 2'b00};
      tae_pkg::CL_ADD_SP_SP: add_b = {23'h0, ins[6:0], 2'b00};
      tae_pkg::CL_ADD_T3:    add_b = imm.value;
      default: ;
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, add_b} + {32'h0, cin};
  assign res = sum[31:0];
  assign ovf = (~(op_a[31] ^ add_b[31])) & (op_a[31] ^ res[31]);
  assign nf  = {res[31], (res == 32'h0), sum[32], ovf};

  always_comb begin
    st  = tae_pkg::ST_OK;
    wr  = 1'b0;
    fw  = 1'b0;
    d   = '0;
    val = res;
    unique case (item.action)
      tae_pkg::ACT_LOAD_REG: begin
        wr  = 1'b1;
        d   = item.load_index;
        val = item.load_value;
      end
      tae_pkg::ACT_LOAD_FLAGS: fw = 1'b1;
      tae_pkg::ACT_NONE: ;
      tae_pkg::ACT_EXEC: begin
        unique case (item.iclass)
          tae_pkg::CL_ADC, tae_pkg::CL_ADD_REG: begin
            d = {1'b0, ins[2:0]}; wr = 1'b1; fw = !item.in_it_block;
          end
          tae_pkg::CL_ADD_IMM3: begin
            d = {1'b0, ins[2:0]}; wr = 1'b1; fw = !item.in_it_block;
          end
          tae_pkg::CL_ADD_IMM8: begin
            d = {1'b0, ins[10:8]}; wr = 1'b1; fw = !item.in_it_block;
          end
          tae_pkg::CL_ADD_RD_SP: begin
            d = {1'b0, ins[10:8]}; wr = 1'b1;
          end
          tae_pkg::CL_ADD_SP_SP: begin
            d = tae_pkg::REG_SP; wr = 1'b1;
          end
          tae_pkg::CL_ADD_HI: begin
            priority if (rd_hi == tae_pkg::REG_SP || ins[6:3] == tae_pkg::REG_SP)
              st = tae_pkg::ST_NOT_IMPL;
            else if (rd_hi == tae_pkg::REG_PC && ins[6:3] == tae_pkg::REG_PC)
              st = tae_pkg::ST_UNPRED;
            else if (rd_hi == tae_pkg::REG_PC && item.in_it_block && !item.last_in_it_block)
              st = tae_pkg::ST_UNPRED;
            else if (rd_hi == tae_pkg::REG_PC)
              st = tae_pkg::ST_NOT_IMPL;
            else begin
              d = rd_hi; wr = 1'b1;
            end
          end
          tae_pkg::CL_ADD_T3: begin
            priority if (rd_t3 == tae_pkg::REG_PC && s_bit) st = tae_pkg::ST_NOT_IMPL;
            else if (rn_t3 == tae_pkg::REG_SP)              st = tae_pkg::ST_NOT_IMPL;
            else if (!imm.ok)                               st = tae_pkg::ST_UNPRED;
            else if (rd_t3 == tae_pkg::REG_SP || rd_t3 == tae_pkg::REG_PC ||
                     rn_t3 == tae_pkg::REG_PC)              st = tae_pkg::ST_UNPRED;
            else begin
              d = rd_t3; wr = 1'b1; fw = s_bit;
            end
          end
          default: st = tae_pkg::ST_NO_MATCH;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    wb.reg_we  = wr;
    wb.reg_idx = wr ? d : 4'h0;
    wb.reg_val = wr ? val : 32'h0;
    wb.flag_we = fw;
    wb.flags   = (item.action == tae_pkg::ACT_LOAD_FLAGS) ? item.load_value[3:0] : nf;
    flags_out  = fw ? wb.flags : flags_in;
  end

  assign status = st;

endmodule

// ===== sv/thumb_add_execute_unit.sv =====
// ----------------------------------------------------------------------------
// thumb_add_execute_unit
// Executes Thumb ADD-family instructions and register/flag preset requests
// against a 16 x 32 register file and NZCV flags.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | in        | in_valid / in_ready   | action, instruction, wide, IT bits, load
//  out_    | out       | out_valid / out_ready | status, register write, flags
//
//  One request per cycle sustained while out_ready is high; out_valid rises once
//  a request passes the input register (operand read), then the result register.
//  Operands are read from the register file at acceptance with a bypass from
//  the request ahead, so dependent requests run back to back.
//  Reset clears the register file, the flags and both valid bits.
//  A stalled result holds; one more request waits in the input register.
module thumb_add_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_instruction,
  input  logic        in_is_wide,
  input  logic        in_in_it_block,
  input  logic        in_last_in_it_block,
  input  logic [3:0]  in_load_index,
  input  logic [31:0] in_load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_reg_written,
  output logic [3:0]  out_dest_index,
  output logic [31:0] out_dest_value,
  output logic        out_flags_written,
  output logic [3:0]  out_flags_now
);

  logic             stage_valid_r, stage_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  tae_pkg::item_t   item_r;
  tae_pkg::iclass_t in_class;
  tae_pkg::raddr_t  raddr;
  logic             accept, advance;
  logic [31:0]      op_a, op_b;
  logic [3:0]       flags_rd;
  tae_pkg::wb_t     wb;
  tae_pkg::status_t status;
  logic [3:0]       flags_out;

  logic [1:0]  status_r;
  logic        reg_written_r;
  logic [3:0]  dest_index_r;
  logic [31:0] dest_value_r;
  logic        flags_written_r;
  logic [3:0]  flags_now_r;

  assign advance  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;
  assign accept   = in_valid && in_ready;

  assign in_class = tae_pkg::classify(in_instruction, in_is_wide);
  assign raddr    = tae_pkg::operand_addr(in_class, in_instruction);

  always_comb begin
    stage_valid_nxt = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_r);
    out_valid_nxt   = advance ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action           <= tae_pkg::action_t'(in_action);
      item_r.instruction      <= in_instruction;
      item_r.in_it_block      <= in_in_it_block;
      item_r.last_in_it_block <= in_last_in_it_block;
      item_r.load_index       <= in_load_index;
      item_r.load_value       <= in_load_value;
      item_r.iclass           <= in_class;
    end
  end

  tae_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (accept),
    .raddr (raddr),
    .wr_en (advance),
    .wb    (wb),
    .op_a  (op_a),
    .op_b  (op_b),
    .flags (flags_rd)
  );

  tae_execute u_execute (
    .item      (item_r),
    .op_a      (op_a),
    .op_b      (op_b),
    .flags_in  (flags_rd),
    .wb        (wb),
    .status    (status),
    .flags_out (flags_out)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r        <= status;
      reg_written_r   <= wb.reg_we;
      dest_index_r    <= wb.reg_idx;
      dest_value_r    <= wb.reg_val;
      flags_written_r <= wb.flag_we;
      flags_now_r     <= flags_out;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_reg_written   = reg_written_r;
  assign out_dest_index    = dest_index_r;
  assign out_dest_value    = dest_value_r;
  assign out_flags_written = flags_written_r;
  assign out_flags_now     = flags_now_r;

endmodule

// ===== sv/tae_checker.sv =====
// ----------------------------------------------------------------------------
// tae_checker
// Port-level checks for the Thumb ADD execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module tae_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_reg_written,
  input logic [3:0]  out_dest_index,
  input logic [31:0] out_dest_value,
  input logic        out_flags_written,
  input logic [3:0]  out_flags_now
);

  // flags as last delivered; reset value is zero
  logic [3:0] last_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_flags_r <= '0;
    end else if (out_valid && out_ready) begin
      last_flags_r <= out_flags_now;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest_value) && $stable(out_status))
    else $error("stalled result changed");

  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tae_pkg::ST_OK |->
      !out_reg_written && !out_flags_written && out_dest_index == 4'h0 &&
      out_dest_value == 32'h0)
    else $error("write reported with error status");

  a_no_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_written |-> out_dest_index == 4'h0 && out_dest_value == 32'h0)
    else $error("destination fields set without register write");

  a_flags_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flags_written |-> out_flags_now == last_flags_r)
    else $error("flags changed without flag write");

endmodule

bind thumb_add_execute_unit tae_checker u_tae_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_reg_written   (out_reg_written),
  .out_dest_index    (out_dest_index),
  .out_dest_value    (out_dest_value),
  .out_flags_written (out_flags_written),
  .out_flags_now     (out_flags_now)
);

// ===== test/add_exec_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// add_exec_scoreboard
// Request/result types and a scoreboard that mirrors the register file and
// NZCV flags of the Thumb ADD execute unit and checks every result in order.
// ----------------------------------------------------------------------------
package add_exec_check_pkg;

  typedef struct packed {
    tae_pkg::action_t action;
    logic [31:0]      instruction;
    logic             is_wide;
    logic             in_it_block;
    logic             last_in_it_block;
    logic [3:0]       load_index;
    logic [31:0]      load_value;
  } add_request_t;

  typedef struct packed {
    tae_pkg::status_t status;
    logic             reg_written;
    logic [3:0]       dest_index;
    logic [31:0]      dest_value;
    logic             flags_written;
    logic [3:0]       flags_now;
  } add_result_t;

  class add_result_scoreboard;
    logic [31:0]  shadow_regs [16];
    logic [3:0]   shadow_nzcv;
    add_result_t  expected_results [$];
    int unsigned  mismatch_count;

    function new();
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      shadow_nzcv    = '0;
      mismatch_count = 0;
    endfunction

    // {N, Z, C, V, sum}
    static function logic [35:0] add_with_carry(input logic [31:0] a, input logic [31:0] b,
                                                input logic cin);
      logic [32:0] s;
      logic        v;
      s = {1'b0, a} + {1'b0, b} + {32'h0, cin};
      v = (a[31] == b[31]) && (s[31] != a[31]);
      return {s[31], s[31:0] == 32'h0, s[32], v, s[31:0]};
    endfunction

    // {valid, value}; replicated patterns need a nonzero byte
    static function logic [32:0] expand_modified_imm(input logic [11:0] imm12);
      logic [7:0]  b;
      logic [31:0] unrot;
      logic [4:0]  rot;
      b = imm12[7:0];
      if (imm12[11:10] == 2'b00) begin
        case (imm12[9:8])
          2'd0:    return {1'b1, 24'h0, b};
          2'd1:    return {b != 8'h0, 8'h0, b, 8'h0, b};
          2'd2:    return {b != 8'h0, b, 8'h0, b, 8'h0};
          default: return {b != 8'h0, b, b, b, b};
        endcase
      end
      unrot = {24'h0, 1'b1, imm12[6:0]};
      rot   = imm12[11:7];
      return {1'b1, (unrot >> rot) | (unrot << (6'd32 - rot))};
    endfunction

    function add_result_t execute(input add_request_t rq);
      add_result_t      r;
      tae_pkg::status_t st;
      logic [15:0]      h;
      logic [31:0]      ins;
      logic [3:0]       rd, rn, rm, nf;
      logic [31:0]      res;
      logic [32:0]      imm;
      logic             narrow, upd, wr, fw, s_bit;
      ins    = rq.instruction;
      h      = ins[15:0];
      narrow = !rq.is_wide && (ins[31:16] == 16'h0);
      upd    = !rq.in_it_block;
      st     = tae_pkg::ST_OK;
      wr     = 1'b0;
      fw     = 1'b0;
      rd     = '0;
      res    = '0;
      nf     = '0;
      case (rq.action)
        tae_pkg::ACT_LOAD_REG: begin
          wr  = 1'b1;
          rd  = rq.load_index;
          res = rq.load_value;
        end
        tae_pkg::ACT_LOAD_FLAGS: begin
          fw = 1'b1;
          nf = rq.load_value[3:0];
        end
        tae_pkg::ACT_EXEC: begin
          if (narrow && (h & tae_pkg::MASK_ADC) == tae_pkg::PAT_ADC) begin
            rd = {1'b0, h[2:0]};
            {nf, res} = add_with_carry(shadow_regs[rd], shadow_regs[{1'b0, h[5:3]}],
                                       shadow_nzcv[1]);
            wr = 1'b1;
            fw = upd;
          end else if (narrow && (h & tae_pkg::MASK_IMM3) == tae_pkg::PAT_IMM3) begin
            rd = {1'b0, h[2:0]};
            {nf, res} = add_with_carry(shadow_regs[{1'b0, h[5:3]}], {29'h0, h[8:6]}, 1'b0);
            wr = 1'b1;
            fw = upd;
          end else if (narrow && (h & tae_pkg::MASK_IMM8) == tae_pkg::PAT_IMM8) begin
            rd = {1'b0, h[10:8]};
            {nf, res} = add_with_carry(shadow_regs[rd], {24'h0, h[7:0]}, 1'b0);
            wr = 1'b1;
            fw = upd;
          end else if (narrow && (h & tae_pkg::MASK_REG) == tae_pkg::PAT_REG) begin
            rd = {1'b0, h[2:0]};
            {nf, res} = add_with_carry(shadow_regs[{1'b0, h[5:3]}],
                                       shadow_regs[{1'b0, h[8:6]}], 1'b0);
            wr = 1'b1;
            fw = upd;
          end else if (narrow && (h & tae_pkg::MASK_RD_SP) == tae_pkg::PAT_RD_SP) begin
            rd  = {1'b0, h[10:8]};
            res = shadow_regs[tae_pkg::REG_SP] + {22'h0, h[7:0], 2'b00};
            wr  = 1'b1;
          end else if (narrow && (h & tae_pkg::MASK_SP_SP) == tae_pkg::PAT_SP_SP) begin
            rd  = tae_pkg::REG_SP;
            res = shadow_regs[tae_pkg::REG_SP] + {23'h0, h[6:0], 2'b00};
            wr  = 1'b1;
          end else if (narrow && (h & tae_pkg::MASK_HI) == tae_pkg::PAT_HI) begin
            rm = h[6:3];
            rn = {h[7], h[2:0]};
            if (rn == tae_pkg::REG_SP || rm == tae_pkg::REG_SP)
              st = tae_pkg::ST_NOT_IMPL;
            else if (rn == tae_pkg::REG_PC && rm == tae_pkg::REG_PC)
              st = tae_pkg::ST_UNPRED;
            else if (rn == tae_pkg::REG_PC && rq.in_it_block && !rq.last_in_it_block)
              st = tae_pkg::ST_UNPRED;
            else if (rn == tae_pkg::REG_PC)
              st = tae_pkg::ST_NOT_IMPL;
            else begin
              rd = rn;
              {nf, res} = add_with_carry(shadow_regs[rn], shadow_regs[rm], 1'b0);
              wr = 1'b1;
            end
          end else if (rq.is_wide && (ins & tae_pkg::MASK_T3) == tae_pkg::PAT_T3) begin
            rn    = ins[19:16];
            s_bit = ins[20];
            imm   = expand_modified_imm({ins[26], ins[14:12], ins[7:0]});
            if (ins[11:8] == tae_pkg::REG_PC && s_bit) st = tae_pkg::ST_NOT_IMPL;
            else if (rn == tae_pkg::REG_SP) st = tae_pkg::ST_NOT_IMPL;
            else if (!imm[32]) st = tae_pkg::ST_UNPRED;
            else if (ins[11:8] == tae_pkg::REG_SP ||
                     (ins[11:8] == tae_pkg::REG_PC && !s_bit) || rn == tae_pkg::REG_PC)
              st = tae_pkg::ST_UNPRED;
            else begin
              rd = ins[11:8];
              {nf, res} = add_with_carry(shadow_regs[rn], imm[31:0], 1'b0);
              wr = 1'b1;
              fw = s_bit;
            end
          end else begin
            st = tae_pkg::ST_NO_MATCH;
          end
        end
        default: ;
      endcase
      if (st != tae_pkg::ST_OK) begin
        wr  = 1'b0;
        fw  = 1'b0;
        rd  = '0;
        res = '0;
      end
      if (wr) shadow_regs[rd] = res;
      if (fw) shadow_nzcv = nf;
      r.status        = st;
      r.reg_written   = wr;
      r.dest_index    = rd;
      r.dest_value    = res;
      r.flags_written = fw;
      r.flags_now     = shadow_nzcv;
      return r;
    endfunction

    function void note_request(input add_request_t rq);
      expected_results.push_back(execute(rq));
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void check_result(input add_result_t got);
      add_result_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: st=%0d wr=%0b d=%0d v=%h fw=%0b f=%h",
                   got.status, got.reg_written, got.dest_index, got.dest_value,
                   got.flags_written, got.flags_now);
        return;
      end
      want = expected_results.pop_front();
      if (got.status != want.status || got.reg_written != want.reg_written ||
          got.dest_index != want.dest_index || got.dest_value != want.dest_value ||
          got.flags_written != want.flags_written || got.flags_now != want.flags_now) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result mismatch at %0t: exp st=%0d wr=%0b d=%0d v=%h fw=%0b f=%h",
                   $realtime, want.status, want.reg_written, want.dest_index,
                   want.dest_value, want.flags_written, want.flags_now);
          $display("  got st=%0d wr=%0b d=%0d v=%h fw=%0b f=%h",
                   got.status, got.reg_written, got.dest_index, got.dest_value,
                   got.flags_written, got.flags_now);
        end
      end
    endfunction
  endclass

endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ADD-family instructions and register/flag presets into the Thumb ADD
// execute unit with random idling on both sides, and checks each result
// against a mirrored register file and flags.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [31:0] in_instruction;
  logic        in_is_wide;
  logic        in_in_it_block;
  logic        in_last_in_it_block;
  logic [3:0]  in_load_index;
  logic [31:0] in_load_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic        out_reg_written;
  logic [3:0]  out_dest_index;
  logic [31:0] out_dest_value;
  logic        out_flags_written;
  logic [3:0]  out_flags_now;

  add_exec_check_pkg::add_result_scoreboard sb;
  bit idle_on;
  bit hold_output;

  thumb_add_execute_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_instruction      (in_instruction),
    .in_is_wide          (in_is_wide),
    .in_in_it_block      (in_in_it_block),
    .in_last_in_it_block (in_last_in_it_block),
    .in_load_index       (in_load_index),
    .in_load_value       (in_load_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_reg_written     (out_reg_written),
    .out_dest_index      (out_dest_index),
    .out_dest_value      (out_dest_value),
    .out_flags_written   (out_flags_written),
    .out_flags_now       (out_flags_now)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic add_exec_check_pkg::add_request_t make_exec(
      input logic [31:0] ins, input logic wide, input logic in_it, input logic last_it);
    add_exec_check_pkg::add_request_t rq;
    rq                  = '0;
    rq.action           = tae_pkg::ACT_EXEC;
    rq.instruction      = ins;
    rq.is_wide          = wide;
    rq.in_it_block      = in_it;
    rq.last_in_it_block = last_it;
    return rq;
  endfunction

  function automatic add_exec_check_pkg::add_request_t make_load(
      input tae_pkg::action_t act, input logic [3:0] idx, input logic [31:0] val);
    add_exec_check_pkg::add_request_t rq;
    rq            = '0;
    rq.action     = act;
    rq.load_index = idx;
    rq.load_value = val;
    return rq;
  endfunction

  function automatic add_exec_check_pkg::add_request_t random_request();
    add_exec_check_pkg::add_request_t rq;
    int unsigned  pick;
    logic [3:0]   rd, rn;
    rq.action           = tae_pkg::ACT_EXEC;
    rq.instruction      = $urandom;
    rq.is_wide          = 1'b0;
    rq.in_it_block      = ($urandom_range(0, 3) == 0);
    rq.last_in_it_block = 1'($urandom_range(0, 1));
    rq.load_index       = 4'($urandom_range(0, 15));
    rq.load_value       = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      rq.action     = tae_pkg::ACT_LOAD_REG;
      rq.load_value = corner_value();
    end else if (pick < 18) begin
      rq.action = tae_pkg::ACT_LOAD_FLAGS;
    end else if (pick < 20) begin
      rq.action = tae_pkg::ACT_NONE;
    end else begin
      rd = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 12));
      rn = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 12));
      rq.instruction[31:16] = '0;
      case ($urandom_range(0, 9))
        0: rq.instruction[15:6] = tae_pkg::PAT_ADC[15:6];
        1: rq.instruction[15:9] = tae_pkg::PAT_IMM3[15:9];
        2: rq.instruction[15:11] = tae_pkg::PAT_IMM8[15:11];
        3: rq.instruction[15:9] = tae_pkg::PAT_REG[15:9];
        4: rq.instruction[15:11] = tae_pkg::PAT_RD_SP[15:11];
        5: rq.instruction[15:7] = tae_pkg::PAT_SP_SP[15:7];
        6: rq.instruction[15:8] = tae_pkg::PAT_HI[15:8];
        7, 8: begin
          rq.is_wide     = 1'b1;
          rq.instruction = tae_pkg::PAT_T3 | (32'($urandom_range(0, 1)) << 26)
                         | (32'($urandom_range(0, 1)) << 20) | (32'(rn) << 16)
                         | (32'($urandom_range(0, 7)) << 12) | (32'(rd) << 8)
                         | 32'($urandom_range(0, 255));
        end
        default: begin
          // noise: most of it matches nothing
          rq.instruction = $urandom;
          rq.is_wide     = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 1)) rq.instruction[31:16] = '0;
        end
      endcase
    end
    return rq;
  endfunction

  task automatic send_request(input add_exec_check_pkg::add_request_t rq);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_action           <= rq.action;
    in_instruction      <= rq.instruction;
    in_is_wide          <= rq.is_wide;
    in_in_it_block      <= rq.in_it_block;
    in_last_in_it_block <= rq.last_in_it_block;
    in_load_index       <= rq.load_index;
    in_load_value       <= rq.load_value;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_request(make_load(tae_pkg::ACT_LOAD_REG, 4'd0, 32'hffff_ffff));
    send_request(make_load(tae_pkg::ACT_LOAD_REG, 4'd1, 32'h0000_0001));
    send_request(make_load(tae_pkg::ACT_LOAD_FLAGS, 4'd0, 32'h0000_0002));
    send_request(make_exec(32'h0000_4148, 1'b0, 1'b0, 1'b0));  // adc with carry in
    send_request(make_load(tae_pkg::ACT_LOAD_REG, 4'd2, 32'h7fff_ffff));
    send_request(make_exec(32'h0000_1dd3, 1'b0, 1'b0, 1'b0));  // signed overflow
    send_request(make_exec(32'h0000_33ff, 1'b0, 1'b1, 1'b0));  // in IT: no flags
    send_request(make_exec(32'h0000_1884, 1'b0, 1'b0, 1'b0));
    send_request(make_load(tae_pkg::ACT_LOAD_REG, tae_pkg::REG_SP, 32'h8000_0000));
    send_request(make_exec(32'h0000_adff, 1'b0, 1'b0, 1'b0));
    send_request(make_exec(32'h0000_b07f, 1'b0, 1'b0, 1'b0));
    send_request(make_exec(32'h0000_4490, 1'b0, 1'b0, 1'b0));
    send_request(make_exec(32'h0000_4485, 1'b0, 1'b0, 1'b0));  // hi add to SP
    send_request(make_exec(32'h0000_44ff, 1'b0, 1'b0, 1'b0));  // pc + pc
    send_request(make_exec(32'h0000_448f, 1'b0, 1'b1, 1'b0));  // pc write mid IT
    send_request(make_exec(32'h0000_448f, 1'b0, 1'b1, 1'b1));  // pc write
    send_request(make_exec(32'hf510_79ff, 1'b1, 1'b0, 1'b0));  // adds, rotated imm
    send_request(make_exec(32'hf110_0f01, 1'b1, 1'b0, 1'b0));  // cmn
    send_request(make_exec(32'hf10d_0101, 1'b1, 1'b0, 1'b0));  // SP base
    send_request(make_exec(32'hf100_1100, 1'b1, 1'b0, 1'b0));  // zero byte pattern
    send_request(make_exec(32'hf100_0d01, 1'b1, 1'b0, 1'b0));  // rd SP
    send_request(make_exec(32'hf10f_0101, 1'b1, 1'b0, 1'b0));  // rn PC
    send_request(make_exec(32'h0000_1c00, 1'b1, 1'b0, 1'b0));  // narrow form, wide set
    send_request(make_exec(32'h0001_1800, 1'b0, 1'b0, 1'b0));  // upper half nonzero
    send_request(make_load(tae_pkg::ACT_NONE, 4'hf, 32'hffff_ffff));
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_output) begin
        repeat (40) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
        hold_output = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 5) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    add_exec_check_pkg::add_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status        = tae_pkg::status_t'(out_status);
      got.reg_written   = out_reg_written;
      got.dest_index    = out_dest_index;
      got.dest_value    = out_dest_value;
      got.flags_written = out_flags_written;
      got.flags_now     = out_flags_now;
      sb.check_result(got);
    end
  end

  initial begin
    sb                  = new();
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_action           = tae_pkg::ACT_EXEC;
    in_instruction      = '0;
    in_is_wide          = 1'b0;
    in_in_it_block      = 1'b0;
    in_last_in_it_block = 1'b0;
    in_load_index       = '0;
    in_load_value       = '0;
    idle_on             = 1'b1;
    hold_output         = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    wait_for_results();
    repeat (150) send_request(random_request());
    idle_on = 1'b0;
    repeat (60) send_request(random_request());
    // receiver stalls long while requests keep coming
    hold_output = 1'b1;
    repeat (30) send_request(random_request());
    wait_for_results();
    idle_on = 1'b1;
    repeat (210) send_request(random_request());

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== thumb_add_execute_unit.f =====
sv/tae_pkg.sv
sv/tae_regfile.sv
sv/tae_execute.sv
sv/thumb_add_execute_unit.sv
sv/tae_checker.sv
test/add_exec_scoreboard.sv
test/testbench.sv
